// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/kbs_pkg.sv =====
package kbs_pkg;

	typedef enum logic [2:0] {
		ST_WAIT       = 3'd0,
		ST_IDLE       = 3'd1,
		ST_PRESSED    = 3'd2,
		ST_RELEASED   = 3'd3,
		ST_WAIT_CHECK = 3'd4
	} scan_state_t;

	localparam logic [2:0] CMD_PRESS   = 3'd0;
	localparam logic [2:0] CMD_RELEASE = 3'd1;
	localparam logic [2:0] CMD_CHECK   = 3'd2;
	localparam logic [2:0] CMD_RESET   = 3'd3;
	localparam logic [2:0] CMD_TICK    = 3'd4;

	localparam logic [7:0] ON_KEY     = 8'h18;
	localparam logic [7:0] WAIT_RESET = 8'd16;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] key_code;
		logic       cpu_sleeping;
		logic       display_on;
	} item_t;

	typedef struct packed {
		logic       key_flag;
		logic       wake;
		logic [7:0] held_key;
		logic       key_is_down;
	} result_t;

endpackage

// ===== hw/rtl/calculator_keyboard_scanner.sv =====
// Channel   Handshake            Payload
// input     in_valid / in_ready  command, key_code, cpu_sleeping, display_on
// output    out_valid/ out_ready key_flag, wake, held_key, key_is_down
// config    cfg_we               cfg_wdata (wait_count)
//
// One word per cycle while the output is not stalled. A word waits in the input
// register, and its result is captured in the output register as the word
// leaves the input register, which raises out_valid.
// The scanner state advances as the word leaves the input register, so the
// next word always sees the state left by the one before it.
// Reset is asynchronous, active low; wait_count returns to 16, state to wait.
// A stalled output holds its word; in_ready drops only when both stages hold.
module calculator_keyboard_scanner (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] command,
	input  logic [7:0] key_code,
	input  logic       cpu_sleeping,
	input  logic       display_on,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       key_flag,
	output logic       wake,
	output logic [7:0] held_key,
	output logic       key_is_down,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	kbs_pkg::item_t   item_s1;
	logic             valid_s1;
	kbs_pkg::result_t res_comb;
	kbs_pkg::result_t res_s2;
	logic             valid_s2;
	logic             s2_free;
	logic             advance;

	// The output register is free when empty or being emptied this cycle.
	assign s2_free  = !valid_s2 || out_ready;
	assign advance  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	// Input register: take a new word whenever the held one moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.command      <= command;
			item_s1.key_code     <= key_code;
			item_s1.cpu_sleeping <= cpu_sleeping;
			item_s1.display_on   <= display_on;
		end
	end

	// Scanner state machine and its single-pass update.
	kbs_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (advance),
		.item      (item_s1),
		.result    (res_comb)
	);

	// Output register: hold while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid   = valid_s2;
	assign key_flag    = res_s2.key_flag;
	assign wake        = res_s2.wake;
	assign held_key    = res_s2.held_key;
	assign key_is_down = res_s2.key_is_down;

endmodule

// ===== hw/rtl/kbs_engine.sv =====
module kbs_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata,
	input  logic            step,
	input  kbs_pkg::item_t  item,
	output kbs_pkg::result_t result
);

	kbs_pkg::scan_state_t state_q, state_d;
	logic       down_q, down_d;
	logic [7:0] counter_q, counter_d;
	logic [7:0] key_q, key_d;
	logic [7:0] wait_count_q;
	logic       press_ok;
	logic       flag;
	logic       wake;

	assign press_ok = !item.cpu_sleeping || item.display_on || (item.key_code == kbs_pkg::ON_KEY);

	// next state
	always_comb begin
		state_d   = state_q;
		down_d    = down_q;
		counter_d = counter_q;
		key_d     = key_q;
		case (item.command)
			kbs_pkg::CMD_PRESS: begin
				if (press_ok) begin
					key_d  = item.key_code;
					down_d = 1'b1;
					if (state_q == kbs_pkg::ST_IDLE) state_d = kbs_pkg::ST_PRESSED;
				end
			end
			kbs_pkg::CMD_RELEASE: begin
				down_d = 1'b0;
				if (state_q == kbs_pkg::ST_PRESSED) state_d = kbs_pkg::ST_RELEASED;
			end
			kbs_pkg::CMD_CHECK: begin
				if (state_q == kbs_pkg::ST_WAIT_CHECK) begin
					state_d   = kbs_pkg::ST_WAIT;
					counter_d = wait_count_q;
				end
			end
			kbs_pkg::CMD_RESET: begin
				if (state_q == kbs_pkg::ST_RELEASED) state_d = kbs_pkg::ST_WAIT_CHECK;
			end
			kbs_pkg::CMD_TICK: begin
				if (item.cpu_sleeping) begin
					case (state_q)
						kbs_pkg::ST_RELEASED: state_d = kbs_pkg::ST_IDLE;
						kbs_pkg::ST_WAIT: begin
							state_d = down_q ? kbs_pkg::ST_PRESSED : kbs_pkg::ST_IDLE;
						end
						default: state_d = state_q;
					endcase
				end else if (state_q == kbs_pkg::ST_WAIT) begin
					if (counter_q == 8'd0)
						state_d = down_q ? kbs_pkg::ST_PRESSED : kbs_pkg::ST_IDLE;
					else
						counter_d = counter_q - 8'd1;
				end
			end
			default: state_d = state_q;
		endcase
	end

	// result flags
	always_comb begin
		flag = 1'b0;
		wake = 1'b0;
		case (item.command)
			kbs_pkg::CMD_CHECK: begin
				flag = (state_q == kbs_pkg::ST_PRESSED) || (state_q == kbs_pkg::ST_RELEASED);
			end
			kbs_pkg::CMD_TICK: begin
				wake = item.cpu_sleeping && ((state_q == kbs_pkg::ST_PRESSED) ||
					((state_q == kbs_pkg::ST_WAIT) && down_q));
			end
			default: begin
				flag = 1'b0;
				wake = 1'b0;
			end
		endcase
	end

	assign result.key_flag    = flag;
	assign result.wake        = wake;
	assign result.held_key    = key_d;
	assign result.key_is_down = down_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_count_q <= kbs_pkg::WAIT_RESET;
		end else if (cfg_we) begin
			wait_count_q <= cfg_wdata;
		end
	end

	// advance only when the word moves on to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= kbs_pkg::ST_WAIT;
			down_q    <= 1'b0;
			counter_q <= 8'd0;
			key_q     <= 8'd0;
		end else if (step) begin
			state_q   <= state_d;
			down_q    <= down_d;
			counter_q <= counter_d;
			key_q     <= key_d;
		end
	end

endmodule

// ===== hw/rtl/kbs_checker.sv =====
`include "assert_macros.svh"

module kbs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       key_flag,
	input logic       wake,
	input logic [7:0] held_key,
	input logic       key_is_down
);

	logic [10:0] out_word;
	logic        out_stall;

	assign out_word  = {key_flag, wake, held_key, key_is_down};
	assign out_stall = out_valid && !out_ready;

	`ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled word changed")
	`ASSERT_IMPLIES(a_wake_flag_excl, out_valid && wake, !key_flag, "wake and key_flag on one word")
	`ASSERT_IMPLIES(a_wake_needs_down, out_valid && wake, key_is_down, "wake without key down")
	`ASSERT_IMPLIES(a_stall_only_full, !in_ready, out_stall, "input stalled with output free")

endmodule

bind calculator_keyboard_scanner kbs_checker u_kbs_checker (.*);
